// ===== src/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// no dependencies; the including module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check on every clk edge, switched off while reset is held
`define BDBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clk edge, reset included
`define BDBA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDBA_ASSERT(lbl, prop, msg)
`define BDBA_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== src/bdba_pkg.sv =====
// types, codes and microcode rom of the bitmap block allocator
// no dependencies
package bdba_pkg;

  // fixed field widths
  localparam int CMD_W    = 1;
  localparam int LEN_W    = 16;
  localparam int BLKNUM_W = 7;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;
  localparam int K_W      = 5;

  localparam logic [LIMIT_W-1:0] MAX_RESULTS = 5'd16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER_LIM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY   = 2'd3;

  // microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_ALC_CHK   = 4'd1;
  localparam step_t S_ALC_LIM   = 4'd2;
  localparam step_t S_ALC_RD    = 4'd3;
  localparam step_t S_ALC_LD    = 4'd4;
  localparam step_t S_ALC_GRANT = 4'd5;
  localparam step_t S_ALC_END   = 4'd6;
  localparam step_t S_ALC_NEXT  = 4'd7;
  localparam step_t S_FAIL_SPC  = 4'd8;
  localparam step_t S_FAIL_LIM  = 4'd9;
  localparam step_t S_FREE_RD   = 4'd10;
  localparam step_t S_FREE_LD   = 4'd11;
  localparam step_t S_FREE_DO   = 4'd12;

  typedef enum logic [1:0] {RD_NONE, RD_SCAN, RD_FREE} rd_src_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_GRANT, OP_FREE, OP_FAIL_SPACE, OP_FAIL_LIMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_CMD_FREE, C_NO_SPACE, C_OVER_LIMIT, C_WORD_FULL
  } cond_t;

  // one control word
  typedef struct packed {
    logic    in_take;
    rd_src_t rd_src;
    logic    ld_cur;
    op_t     op;
    logic    wr_cur;
    logic    w_inc;
    cond_t   cond;
    step_t   target;
  } ctrl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic cmd_free;
    logic no_space;
    logic over_limit;
    logic word_full;
    logic last_grant;
  } flags_t;

  // microcode rom
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      S_IDLE:      c = '{1'b1, RD_NONE, 1'b0, OP_NONE,       1'b0, 1'b0, C_CMD_FREE,
                         S_FREE_RD};
      S_ALC_CHK:   c = '{1'b0, RD_NONE, 1'b0, OP_NONE,       1'b0, 1'b0, C_NO_SPACE,
                         S_FAIL_SPC};
      S_ALC_LIM:   c = '{1'b0, RD_NONE, 1'b0, OP_NONE,       1'b0, 1'b0, C_OVER_LIMIT,
                         S_FAIL_LIM};
      S_ALC_RD:    c = '{1'b0, RD_SCAN, 1'b0, OP_NONE,       1'b0, 1'b0, C_NEVER, S_IDLE};
      S_ALC_LD:    c = '{1'b0, RD_NONE, 1'b1, OP_NONE,       1'b0, 1'b0, C_NEVER, S_IDLE};
      S_ALC_GRANT: c = '{1'b0, RD_NONE, 1'b0, OP_GRANT,      1'b0, 1'b0, C_WORD_FULL,
                         S_ALC_NEXT};
      S_ALC_END:   c = '{1'b0, RD_NONE, 1'b0, OP_NONE,       1'b1, 1'b0, C_ALWAYS, S_IDLE};
      S_ALC_NEXT:  c = '{1'b0, RD_NONE, 1'b0, OP_NONE,       1'b1, 1'b1, C_ALWAYS, S_ALC_RD};
      S_FAIL_SPC:  c = '{1'b0, RD_NONE, 1'b0, OP_FAIL_SPACE, 1'b0, 1'b0, C_ALWAYS, S_IDLE};
      S_FAIL_LIM:  c = '{1'b0, RD_NONE, 1'b0, OP_FAIL_LIMIT, 1'b0, 1'b0, C_ALWAYS, S_IDLE};
      S_FREE_RD:   c = '{1'b0, RD_FREE, 1'b0, OP_NONE,       1'b0, 1'b0, C_NEVER, S_IDLE};
      S_FREE_LD:   c = '{1'b0, RD_NONE, 1'b1, OP_NONE,       1'b0, 1'b0, C_NEVER, S_IDLE};
      S_FREE_DO:   c = '{1'b0, RD_NONE, 1'b0, OP_FREE,       1'b0, 1'b0, C_ALWAYS, S_IDLE};
      default:     c = '{1'b0, RD_NONE, 1'b0, OP_NONE,       1'b0, 1'b0, C_ALWAYS, S_IDLE};
    endcase
    return c;
  endfunction

endpackage

// ===== src/bdba_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bdba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bdba_useq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
// depends on bdba_pkg
module bdba_useq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bdba_pkg::flags_t       flags,
  output bdba_pkg::ctrl_t        ctrl,
  output bdba_pkg::step_t        step
);

  bdba_pkg::step_t step_r, step_nxt;
  logic            hold;
  logic            jump;

  // control word of the current step
  assign ctrl = bdba_pkg::ucode(step_r);
  assign step = step_r;

  // hold while waiting for a beat or output space, or while granting
  always_comb begin
    unique case (ctrl.op) inside
      bdba_pkg::OP_GRANT:
        hold = !flags.word_full && !(flags.out_free && flags.last_grant);
      bdba_pkg::OP_FREE, bdba_pkg::OP_FAIL_SPACE, bdba_pkg::OP_FAIL_LIMIT:
        hold = !flags.out_free;
      default:
        hold = 1'b0;
    endcase
    if (ctrl.in_take && !flags.in_fire) begin
      hold = 1'b1;
    end
  end

  // jump condition decode
  always_comb begin
    unique case (ctrl.cond)
      bdba_pkg::C_NEVER:      jump = 1'b0;
      bdba_pkg::C_ALWAYS:     jump = 1'b1;
      bdba_pkg::C_CMD_FREE:   jump = flags.cmd_free;
      bdba_pkg::C_NO_SPACE:   jump = flags.no_space;
      bdba_pkg::C_OVER_LIMIT: jump = flags.over_limit;
      bdba_pkg::C_WORD_FULL:  jump = flags.word_full;
      default:                jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bdba_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/bitmap_disk_block_allocator_top.sv =====
// top level of the first-fit bitmap disk block allocator
// depends on bdba_pkg, bdba_ram, bdba_useq and assert_macros.svh
//
// in_*  : one request beat; in_command picks allocate (byte length) or free
//         (block number). in_ready is high only in the idle step, one at a time.
// out_* : allocate gives one beat per granted block, out_last on the final one;
//         a refused allocate or any free gives one beat with out_last set.
// cfg_* : cfg_we writes the per-file block limit (reset 10); write it when idle.
// sequence, from the accepting idle step:
//   free: read the word, load it, then emit the result and clear the bit if set.
//   refusal: the space check (no space) or limit check (over limit) leads to
//   a fail step that emits the result.
//   allocate: check space and limit, read the first word, load it from the
//   registered ram read, then grant one block per cycle while the output is
//   free; each word that is full or fills before the last grant adds a detect,
//   write-back, read and load step; a write-back step ends the request.
// reset: word 0 reads as used and all others as free through per-word valid
//   bits; the free count loads all blocks but word 0, the limit 10.
// stall: with out_ready low the output register holds its beat and the
//   sequencer waits; nothing is lost.
`include "assert_macros.svh"
module bitmap_disk_block_allocator_top #(
  parameter int BLOCK_BYTES = 128,
  parameter int MAP_WORDS   = 8,
  parameter int WORD_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdba_pkg::CMD_W-1:0]          in_command,
  input  logic [bdba_pkg::LEN_W-1:0]          in_byte_length,
  input  logic [bdba_pkg::BLKNUM_W-1:0]       in_block_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bdba_pkg::STATUS_W-1:0]       out_status,
  output logic [bdba_pkg::BLKNUM_W-1:0]       out_granted_block,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [bdba_pkg::LIMIT_W-1:0]        cfg_wdata
);

  localparam int TOTAL    = MAP_WORDS * WORD_BITS;
  localparam int WIDX_W   = $clog2(MAP_WORDS);
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int FC_W     = $clog2(TOTAL + 1);
  localparam int FC_RESET = TOTAL - WORD_BITS;

  // sequencer
  bdba_pkg::ctrl_t  ctrl;
  bdba_pkg::flags_t flags;
  bdba_pkg::step_t  step;

  // registers
  logic [bdba_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [bdba_pkg::BLKNUM_W-1:0] blk_r, blk_nxt;
  logic [WIDX_W-1:0]             w_r, w_nxt;
  logic [bdba_pkg::K_W-1:0]      k_r, k_nxt;
  logic [WORD_BITS-1:0]          cur_r, cur_nxt;
  logic [FC_W-1:0]               fc_r, fc_nxt;
  logic [bdba_pkg::LIMIT_W-1:0]  lim_r, lim_nxt;
  logic [MAP_WORDS-1:0]          valid_r, valid_nxt;
  logic                          rd_valid_r, rd_valid_nxt;
  logic                          rd_word0_r, rd_word0_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bdba_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bdba_pkg::BLKNUM_W-1:0] out_block_r, out_block_nxt;
  logic                          out_last_r, out_last_nxt;

  // datapath signals
  logic                          in_fire;
  logic                          out_free;
  logic [bdba_pkg::LIMIT_W-1:0]  limit;
  logic                          no_space;
  logic                          over_limit;
  logic                          last_grant;
  logic                          ff_any;
  logic [BIT_W-1:0]              ff_pos;
  logic                          word_full;
  logic [WIDX_W-1:0]             fw;
  logic [BIT_W-1:0]              fb;
  logic                          f_in;
  logic                          f_hit;
  logic                          grant_fire;
  logic                          free_fire;
  logic                          free_clr;
  logic                          emit;
  logic [31:0]                   gb_full;
  logic                          rd_en;
  logic [WIDX_W-1:0]             rd_addr;
  logic [WORD_BITS-1:0]          rd_data;
  logic [WORD_BITS-1:0]          eff_word;
  logic                          wr_en;
  logic [WIDX_W-1:0]             wr_addr;
  logic [WORD_BITS-1:0]          wr_data;

  assign in_ready = ctrl.in_take;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // effective per-file limit, capped at the most results per request
  assign limit = (lim_r > bdba_pkg::MAX_RESULTS) ? bdba_pkg::MAX_RESULTS : lim_r;

  // block need compared in bytes: need > n exactly when length > n blocks of bytes
  assign no_space   = 32'(len_r) > (32'(fc_r) * BLOCK_BYTES);
  assign over_limit = 32'(len_r) > (32'(limit) * BLOCK_BYTES);
  assign last_grant = ((32'(k_r) + 32'd1) * BLOCK_BYTES) >= 32'(len_r);

  // lowest clear bit of the loaded word
  always_comb begin
    ff_any = 1'b0;
    ff_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!cur_r[i]) begin
        ff_any = 1'b1;
        ff_pos = BIT_W'(i);
      end
    end
  end
  assign word_full = !ff_any;

  // word and bit of the block to free
  always_comb begin
    fw   = '0;
    fb   = '0;
    f_in = 1'b0;
    for (int w = 0; w < MAP_WORDS; w++) begin
      if (32'(blk_r) >= 32'(w * WORD_BITS) && 32'(blk_r) < 32'((w + 1) * WORD_BITS)) begin
        fw   = WIDX_W'(w);
        fb   = BIT_W'(32'(blk_r) - 32'(w * WORD_BITS));
        f_in = 1'b1;
      end
    end
  end
  assign f_hit = f_in && cur_r[fb];

  // actions of the current step
  assign grant_fire = (ctrl.op == bdba_pkg::OP_GRANT) && out_free && !word_full;
  assign free_fire  = (ctrl.op == bdba_pkg::OP_FREE) && out_free;
  assign free_clr   = free_fire && f_hit;
  assign emit       = out_free && (ctrl.op != bdba_pkg::OP_NONE) &&
                      ((ctrl.op != bdba_pkg::OP_GRANT) || !word_full);
  assign gb_full    = 32'(w_r) * WORD_BITS + 32'(ff_pos);

  // flags to the sequencer
  assign flags = '{in_fire:    in_fire,
                   out_free:   out_free,
                   cmd_free:   (in_command == bdba_pkg::CMD_FREE),
                   no_space:   no_space,
                   over_limit: over_limit,
                   word_full:  word_full,
                   last_grant: last_grant};

  bdba_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .step  (step)
  );

  // bitmap ram ports
  assign rd_en    = (ctrl.rd_src != bdba_pkg::RD_NONE);
  assign rd_addr  = (ctrl.rd_src == bdba_pkg::RD_FREE) ? fw : w_r;
  assign wr_en    = ctrl.wr_cur || free_clr;
  assign wr_addr  = free_clr ? fw : w_r;
  assign wr_data  = free_clr ? (cur_r & ~(WORD_BITS'(1) << fb)) : cur_r;
  assign eff_word = rd_valid_r ? rd_data : (rd_word0_r ? {WORD_BITS{1'b1}} : '0);

  bdba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // request latch, scan counters and working word
  always_comb begin
    len_nxt      = len_r;
    blk_nxt      = blk_r;
    w_nxt        = w_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    rd_valid_nxt = rd_valid_r;
    rd_word0_nxt = rd_word0_r;
    if (in_fire) begin
      len_nxt = (in_byte_length == '0) ? bdba_pkg::LEN_W'(1) : in_byte_length;
      blk_nxt = in_block_number;
      w_nxt   = '0;
      k_nxt   = '0;
    end
    if (ctrl.w_inc) begin
      w_nxt = w_r + 1'b1;
    end
    if (grant_fire) begin
      k_nxt   = k_r + 1'b1;
      cur_nxt = cur_r | (WORD_BITS'(1) << ff_pos);
    end
    if (ctrl.ld_cur) begin
      cur_nxt = eff_word;
    end
    if (rd_en) begin
      rd_valid_nxt = valid_r[rd_addr];
      rd_word0_nxt = (rd_addr == '0);
    end
  end

  // free count, word valid bits and limit register
  always_comb begin
    fc_nxt    = fc_r;
    valid_nxt = valid_r;
    lim_nxt   = lim_r;
    if (grant_fire) begin
      fc_nxt = fc_r - 1'b1;
    end else if (free_clr) begin
      fc_nxt = fc_r + 1'b1;
    end
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (cfg_we) begin
      lim_nxt = cfg_wdata;
    end
  end

  // output register
  always_comb begin
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      unique case (ctrl.op)
        bdba_pkg::OP_GRANT: begin
          out_status_nxt = bdba_pkg::ST_OK;
          out_block_nxt  = gb_full[bdba_pkg::BLKNUM_W-1:0];
          out_last_nxt   = last_grant;
        end
        bdba_pkg::OP_FREE: begin
          out_status_nxt = f_hit ? bdba_pkg::ST_OK : bdba_pkg::ST_ALREADY;
          out_block_nxt  = blk_r;
          out_last_nxt   = 1'b1;
        end
        bdba_pkg::OP_FAIL_SPACE: begin
          out_status_nxt = bdba_pkg::ST_NO_SPACE;
          out_block_nxt  = '0;
          out_last_nxt   = 1'b1;
        end
        default: begin
          out_status_nxt = bdba_pkg::ST_OVER_LIM;
          out_block_nxt  = '0;
          out_last_nxt   = 1'b1;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= '0;
      k_r         <= '0;
      fc_r        <= FC_W'(FC_RESET);
      valid_r     <= '0;
      lim_r       <= bdba_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      w_r         <= w_nxt;
      k_r         <= k_nxt;
      fc_r        <= fc_nxt;
      valid_r     <= valid_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    blk_r        <= blk_nxt;
    cur_r        <= cur_nxt;
    rd_valid_r   <= rd_valid_nxt;
    rd_word0_r   <= rd_word0_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_block_r;
  assign out_last          = out_last_r;

  // checks
  `BDBA_ASSERT_NR(a_reset_idle, !rst_n |=> (step == bdba_pkg::S_IDLE), "not idle after reset")
  `BDBA_ASSERT(a_fc_range, fc_r <= FC_W'(TOTAL), "free count beyond disk size")
  `BDBA_ASSERT(a_grant_cap, k_r <= bdba_pkg::MAX_RESULTS, "too many grants for one request")
  `BDBA_ASSERT(a_last_ends, grant_fire && last_grant |=> step == bdba_pkg::S_ALC_END, "no end")
  `BDBA_ASSERT(a_free_count, free_clr |=> fc_r == FC_W'($past(fc_r) + 1'b1), "free not counted")

endmodule
